FILE: hdl/gpd_pkg.sv
`timescale 1ns / 1ps

package gpd_pkg;

  // width of the threshold register, fixed by the register map
  localparam int THRESHOLD_WIDTH = 16;

  // result queue between the detector and the output side
  localparam int OUT_DEPTH = 2;
  localparam int OUT_COUNT_WIDTH = $clog2(OUT_DEPTH + 1);

  localparam logic [OUT_COUNT_WIDTH-1:0] OUT_EMPTY = OUT_COUNT_WIDTH'(0);
  localparam logic [OUT_COUNT_WIDTH-1:0] OUT_ONE = OUT_COUNT_WIDTH'(1);
  localparam logic [OUT_COUNT_WIDTH-1:0] OUT_FULL = OUT_COUNT_WIDTH'(OUT_DEPTH);

endpackage

FILE: hdl/gradient_peak_detector_top.sv
`timescale 1ns / 1ps

// a peak word enters the result queue as the sample that closes it is taken, and shows on m_tdata at the head
// throughput: one sample per cycle while s_tready is high; all detection is one pass of compare logic per sample
// a two-word result queue lets samples keep flowing while one peak waits on m_tready
// s_tready drops only when both result slots are full
// reset (rst, synchronous, active high) clears the record state, the queue and threshold

module gradient_peak_detector_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int INDEX_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,

  // configuration: threshold write
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [gpd_pkg::THRESHOLD_WIDTH-1:0]      cfg_data,  // threshold

  // sample stream in
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,   // sample
  input  logic                                     s_tuser,   // record_start

  // peak stream out
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((INDEX_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata // peak_index, peak_amplitude
);

  localparam int CMP_WIDTH = (SAMPLE_WIDTH > gpd_pkg::THRESHOLD_WIDTH) ?
                             SAMPLE_WIDTH : gpd_pkg::THRESHOLD_WIDTH;
  localparam int WORD_WIDTH = INDEX_WIDTH + SAMPLE_WIDTH;

  // configuration
  logic signed [gpd_pkg::THRESHOLD_WIDTH-1:0] threshold;

  // per-record running state
  logic signed [SAMPLE_WIDTH-1:0] last_sample;
  logic                           last_diff_positive;
  logic        [INDEX_WIDTH-1:0]  sample_count;
  logic                           extremum_valid;
  logic        [INDEX_WIDTH-1:0]  extremum_index;
  logic signed [SAMPLE_WIDTH-1:0] extremum_amplitude;

  // result queue: slot 0 is the head shown on the output
  logic [WORD_WIDTH-1:0]                  out_head;
  logic [WORD_WIDTH-1:0]                  out_tail;
  logic [gpd_pkg::OUT_COUNT_WIDTH-1:0]    out_count;

  logic in_accept;
  logic out_pop;

  // state as seen by this sample, after a record start has cleared it
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] cur_last;
  logic                           cur_dir;
  logic        [INDEX_WIDTH-1:0]  cur_count;
  logic                           cur_ext_valid;
  logic        [INDEX_WIDTH-1:0]  cur_ext_index;
  logic signed [SAMPLE_WIDTH-1:0] cur_ext_amp;

  logic                           have_prev;
  logic                           have_two;
  logic                           rising;
  logic                           turn;
  logic                           emit;
  logic signed [CMP_WIDTH-1:0]    amp_wide;
  logic signed [CMP_WIDTH-1:0]    thr_wide;
  logic        [WORD_WIDTH-1:0]   peak_word;

  logic signed [SAMPLE_WIDTH-1:0] last_sample_next;
  logic                           last_diff_positive_next;
  logic        [INDEX_WIDTH-1:0]  sample_count_next;
  logic                           extremum_valid_next;
  logic        [INDEX_WIDTH-1:0]  extremum_index_next;
  logic signed [SAMPLE_WIDTH-1:0] extremum_amplitude_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (out_count != gpd_pkg::OUT_FULL);
  assign m_tvalid  = (out_count != gpd_pkg::OUT_EMPTY);
  assign in_accept = s_tvalid && s_tready;
  assign out_pop   = m_tvalid && m_tready;

  assign x = s_tdata[SAMPLE_WIDTH-1:0];

  always_comb begin
    // record start wipes the running record state; the threshold and the result queue stay
    if (s_tuser) begin
      cur_last      = '0;
      cur_dir       = 1'b0;
      cur_count     = '0;
      cur_ext_valid = 1'b0;
      cur_ext_index = '0;
      cur_ext_amp   = '0;
    end else begin
      cur_last      = last_sample;
      cur_dir       = last_diff_positive;
      cur_count     = sample_count;
      cur_ext_valid = extremum_valid;
      cur_ext_index = extremum_index;
      cur_ext_amp   = extremum_amplitude;
    end

    have_prev = (cur_count != '0);
    have_two  = (cur_count[INDEX_WIDTH-1:1] != '0);
    // a flat step counts as falling
    rising    = (x > cur_last);
    turn      = have_two && (rising != cur_dir);

    amp_wide = CMP_WIDTH'(cur_ext_amp);
    thr_wide = CMP_WIDTH'(threshold);
    // stored extremum is a peak once a lower extremum follows it and it is at or above the threshold
    emit = turn && cur_ext_valid && (cur_last < cur_ext_amp) && (amp_wide >= thr_wide);

    peak_word = {cur_ext_amp, cur_ext_index};

    // index stops at all ones
    sample_count_next = (&cur_count) ? cur_count : cur_count + 1'b1;
    last_sample_next  = x;
    last_diff_positive_next = have_prev ? rising : cur_dir;

    if (turn) begin
      extremum_valid_next     = 1'b1;
      extremum_index_next     = cur_count - 1'b1;
      extremum_amplitude_next = cur_last;
    end else begin
      extremum_valid_next     = cur_ext_valid;
      extremum_index_next     = cur_ext_index;
      extremum_amplitude_next = cur_ext_amp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample        <= '0;
      last_diff_positive <= 1'b0;
      sample_count       <= '0;
      extremum_valid     <= 1'b0;
      extremum_index     <= '0;
      extremum_amplitude <= '0;
    end else if (in_accept) begin
      last_sample        <= last_sample_next;
      last_diff_positive <= last_diff_positive_next;
      sample_count       <= sample_count_next;
      extremum_valid     <= extremum_valid_next;
      extremum_index     <= extremum_index_next;
      extremum_amplitude <= extremum_amplitude_next;
    end
  end

  // two-slot result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= gpd_pkg::OUT_EMPTY;
    end else begin
      case ({in_accept && emit, out_pop})
        2'b10: begin
          out_count <= out_count + 1'b1;
        end
        2'b01: begin
          out_count <= out_count - 1'b1;
        end
        default: begin
          out_count <= out_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({in_accept && emit, out_pop})
      2'b10: begin
        if (out_count == gpd_pkg::OUT_EMPTY) begin
          out_head <= peak_word;
        end else begin
          out_tail <= peak_word;
        end
      end
      2'b01: begin
        out_head <= out_tail;
      end
      2'b11: begin
        if (out_count == gpd_pkg::OUT_ONE) begin
          out_head <= peak_word;
        end else begin
          out_head <= out_tail;
          out_tail <= peak_word;
        end
      end
      default: begin
        out_head <= out_head;
      end
    endcase
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[WORD_WIDTH-1:0] = out_head;
  end

endmodule

FILE: hdl/gpd_checker.sv
`timescale 1ns / 1ps

module gpd_checker (
  input logic clk,
  input logic rst,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((gpd_pkg::OUT_DEPTH*0)+47):0] m_tdata
);

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("peak word present after reset");

  // input only stalls while results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst) !s_tready |-> m_tvalid)
    else $error("input stalled with empty result queue");

  // a new peak word needs a sample taken the cycle before
  a_out_source: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !$past(m_tvalid)) |-> $past(s_tvalid && s_tready))
    else $error("peak word without a sample behind it");

  // threshold writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("threshold write stalled");

  // a waiting peak word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("peak word changed while stalled");

endmodule

bind gradient_peak_detector_top gpd_checker u_gpd_checker (
  .clk(clk),
  .rst(rst),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

FILE: test/gradient_peak_detector_top_tb.sv
`timescale 1ns / 1ps

module gradient_peak_detector_top_tb;

  localparam int SMP_W = 16;
  localparam int IDX_W = 32;
  localparam int S_DATA_W = ((SMP_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((IDX_W + SMP_W + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 272;
  localparam int SETTLE_CYCLES = 4;
  localparam longint LIMIT_NS = 64'd5_000_000;

  // how a directed row is checked
  typedef enum logic [1:0] {
    BY_MODEL,
    NO_PEAK,
    PEAK
  } chk_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [SMP_W-1:0] amp;
  } peak_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    start;
    chk_t                    chk;
    logic [IDX_W-1:0]        index;
    logic signed [SMP_W-1:0] amp;
  } step_t;

  // directed part, threshold 0
  localparam int N_DIRECTED = 22;
  localparam step_t DIRECTED [0:N_DIRECTED-1] = '{
    // no record start after reset: first sample opens the record
    '{16'sd10,     1'b0, NO_PEAK,  32'd0, 16'sd0},
    '{16'sd20,     1'b0, NO_PEAK,  32'd0, 16'sd0},
    // first extremum, nothing stored yet
    '{16'sd5,      1'b0, NO_PEAK,  32'd0, 16'sd0},
    '{16'sd15,     1'b0, PEAK,     32'd1, 16'sd20},
    // equal samples count as falling
    '{16'sd15,     1'b0, BY_MODEL, 32'd0, 16'sd0},
    // equal extremum amplitudes give no peak
    '{16'sd30,     1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{16'sd0,      1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{16'sd0,      1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{16'sd1,      1'b0, BY_MODEL, 32'd0, 16'sd0},
    // full-scale swings
    '{16'sh7fff,   1'b1, NO_PEAK,  32'd0, 16'sd0},
    '{16'sh8000,   1'b0, NO_PEAK,  32'd0, 16'sd0},
    '{16'sh7fff,   1'b0, NO_PEAK,  32'd0, 16'sd0},
    '{16'sh8000,   1'b0, NO_PEAK,  32'd0, 16'sd0},
    '{16'sh8000,   1'b0, NO_PEAK,  32'd0, 16'sd0},
    '{16'sd0,      1'b0, PEAK,     32'd2, 16'sh7fff},
    // new record drops the pending extremum of the old one
    '{16'sd0,      1'b1, BY_MODEL, 32'd0, 16'sd0},
    '{-16'sd10,    1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{-16'sd20,    1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{-16'sd5,     1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{-16'sd30,    1'b0, BY_MODEL, 32'd0, 16'sd0},
    // stored amplitude below threshold
    '{-16'sd25,    1'b0, BY_MODEL, 32'd0, 16'sd0},
    '{-16'sd40,    1'b0, BY_MODEL, 32'd0, 16'sd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // sample
  logic                s_tuser;   // record_start
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // peak_index, peak_amplitude

  gradient_peak_detector_top #(
    .SAMPLE_WIDTH(SMP_W),
    .INDEX_WIDTH(IDX_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // detector copy: running record state and threshold
  logic signed [SMP_W-1:0] prev_sample;
  bit                      prev_rising;
  logic [IDX_W-1:0]        seen_count;
  bit                      ext_held;
  logic [IDX_W-1:0]        ext_pos;
  logic signed [SMP_W-1:0] ext_val;
  logic signed [15:0]      thr;

  peak_t peak_q[$];
  int    mismatches = 0;
  bit    src_quiet = 1'b0;
  bit    sink_quiet = 1'b0;

  function automatic void clear_record();
    prev_sample = '0;
    prev_rising = 1'b0;
    seen_count = '0;
    ext_held = 1'b0;
    ext_pos = '0;
    ext_val = '0;
  endfunction

  // one sample through the detector; returns 1 with the peak it releases
  function automatic bit detect_peak(input logic signed [SMP_W-1:0] x, input bit start,
                                     output peak_t pk);
    logic [IDX_W-1:0] pos;
    bit rising;
    bit hit;
    hit = 1'b0;
    pk = '0;
    if (start) clear_record();
    pos = seen_count;
    if (seen_count != {IDX_W{1'b1}}) seen_count = seen_count + 1'b1;
    if (pos >= 1) begin
      rising = x > prev_sample;
      if (pos >= 2 && rising != prev_rising) begin
        if (ext_held && prev_sample < ext_val && ext_val >= thr) begin
          pk.index = ext_pos;
          pk.amp = ext_val;
          hit = 1'b1;
        end
        ext_held = 1'b1;
        ext_pos = pos - 1'b1;
        ext_val = prev_sample;
      end
      prev_rising = rising;
    end
    prev_sample = x;
    return hit;
  endfunction

  function automatic int pick_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_sample(input logic signed [SMP_W-1:0] x, input bit start,
                             input chk_t chk, input peak_t typed);
    int gap;
    bit hit;
    peak_t pk;
    if ($urandom_range(0, 39) == 0) src_quiet = ~src_quiet;
    gap = pick_wait(src_quiet);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= S_DATA_W'(x);
    s_tuser <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hit = detect_peak(x, start, pk);
    case (chk)
      BY_MODEL: begin
        if (hit) peak_q = {peak_q, pk};
      end
      PEAK: begin
        peak_q = {peak_q, typed};
      end
      default: begin
      end
    endcase
  endtask

  // only called with no samples in flight
  task automatic write_threshold(input logic signed [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // wait for every pending peak, then let a sample with no result finish
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // records of random length in a few shapes, with stray record starts as noise
  task automatic run_records(input int n_items);
    int left;
    int len;
    int style;
    int cur;
    int base;
    int k;
    int step;
    bit start;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      style = $urandom_range(0, 3);
      base = $signed(16'($urandom));
      cur = base;
      for (k = 0; k < len && left > 0; k++) begin
        case (style)
          0: cur = $signed(16'($urandom));
          1: begin
            step = $urandom_range(0, 6);
            cur = clamp16(cur + step - 3);
          end
          2: begin
            case ($urandom_range(0, 4))
              0: cur = 32767;
              1: cur = -32768;
              2: cur = 0;
              3: cur = -1;
              default: cur = 1;
            endcase
          end
          default: begin
            step = $urandom_range(0, 3);
            cur = clamp16(base + step);
          end
        endcase
        start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        send_sample(SMP_W'(cur), start, BY_MODEL, '0);
        left--;
      end
    end
  endtask

  // peak sink with random stalls
  initial begin : peak_sink
    int w;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = ~sink_quiet;
      w = pick_wait(sink_quiet);
      if (w > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // compare each accepted peak word with the oldest pending one
  always @(posedge clk) begin : check_peaks
    peak_t got;
    peak_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.index = m_tdata[IDX_W-1:0];
      got.amp = m_tdata[IDX_W +: SMP_W];
      if (peak_q.size() == 0) begin
        note_mismatch($sformatf("peak word with none pending: index %0d amplitude %0d",
                                got.index, got.amp));
      end else begin
        want = peak_q.pop_front();
        if (got.index !== want.index)
          note_mismatch($sformatf("peak_index expected %0d got %0d", want.index, got.index));
        if (got.amp !== want.amp)
          note_mismatch($sformatf("peak_amplitude expected %0d got %0d", want.amp, got.amp));
      end
    end
  end

  initial begin : stimulus
    int r;
    int v;
    peak_t typed;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    clear_record();
    thr = '0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_threshold(16'sd0);
    for (r = 0; r < N_DIRECTED; r++) begin
      typed.index = DIRECTED[r].index;
      typed.amp = DIRECTED[r].amp;
      send_sample(DIRECTED[r].sample, DIRECTED[r].start, DIRECTED[r].chk, typed);
    end
    settle();

    // threshold extremes first, then ordinary settings
    write_threshold(16'sh8000);
    run_records(PHASE_ITEMS);
    settle();
    write_threshold(16'sh7fff);
    run_records(PHASE_ITEMS);
    settle();
    write_threshold(16'($urandom));
    run_records(PHASE_ITEMS);
    settle();
    write_threshold(16'sd0);
    run_records(PHASE_ITEMS);
    settle();
    v = $urandom_range(0, 200);
    write_threshold(16'(v - 100));
    run_records(PHASE_ITEMS);
    settle();
    write_threshold(16'($urandom));
    run_records(PHASE_ITEMS);
    settle();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && peak_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
